// ----- hw/rtl/srx_pkg.sv -----
`default_nettype none

package srx_pkg;

   // system size and field widths
   localparam int SPIN_COUNT = 32;
   localparam int STATE_W    = 32;
   localparam int SITE_W     = 5;
   localparam int RING_W     = 4;
   localparam int STRENGTH_W = 32;
   localparam int COEF_W     = 36;

   // at most one diagonal term plus five off-diagonal terms per item
   localparam int MAX_OFF    = 5;
   localparam int MAX_TERMS  = MAX_OFF + 1;
   localparam int TERM_IDX_W = $clog2(MAX_TERMS);
   localparam int OFF_IDX_W  = $clog2(MAX_OFF);

   // spins at or above the system size read as down
   localparam logic [STATE_W-1:0] STATE_MASK =
      (SPIN_COUNT >= STATE_W) ? {STATE_W{1'b1}}
                              : STATE_W'((64'd1 << SPIN_COUNT) - 64'd1);

   // term kinds on the result channel
   localparam logic TERM_DIAG    = 1'b0;
   localparam logic TERM_OFFDIAG = 1'b1;

   typedef enum logic [1:0] {
      RING_PLUS,
      RING_MINUS,
      RING_FLIP
   } ring_kind_type;

   typedef struct packed {
      logic [1:0]    up;
      logic [1:0]    down;
      ring_kind_type kind;
   } ring_term_type;

   // one held input item
   typedef struct packed {
      logic [STATE_W-1:0]           basis_state;
      logic [SITE_W-1:0]            site_first;
      logic [SITE_W-1:0]            site_second;
      logic [SITE_W-1:0]            site_third;
      logic [SITE_W-1:0]            site_fourth;
      logic signed [STRENGTH_W-1:0] ring_strength;
   } item_type;

   // one generated term
   typedef struct packed {
      logic                     term_kind;
      logic [STATE_W-1:0]       target_state;
      logic signed [COEF_W-1:0] coefficient;
      logic                     last_term;
   } term_type;

   localparam ring_term_type NO_TERM = '{2'd0, 2'd0, RING_PLUS};

   // number of off-diagonal terms per spin pattern
   localparam logic [TERM_IDX_W-1:0] RING_COUNT [16] = '{
      3'd0, 3'd3, 3'd3, 3'd4, 3'd3, 3'd5, 3'd4, 3'd3,
      3'd3, 3'd4, 3'd5, 3'd3, 3'd4, 3'd3, 3'd3, 3'd0
   };

   // off-diagonal terms per spin pattern, pattern bit i is the spin of site i
   localparam ring_term_type RING_TABLE [16][MAX_OFF] = '{
      '{NO_TERM, NO_TERM, NO_TERM, NO_TERM, NO_TERM},
      '{'{2'd1, 2'd0, RING_PLUS}, '{2'd3, 2'd0, RING_PLUS}, '{2'd2, 2'd0, RING_MINUS},
        NO_TERM, NO_TERM},
      '{'{2'd0, 2'd1, RING_PLUS}, '{2'd2, 2'd1, RING_PLUS}, '{2'd3, 2'd1, RING_MINUS},
        NO_TERM, NO_TERM},
      '{'{2'd3, 2'd0, RING_MINUS}, '{2'd2, 2'd1, RING_MINUS}, '{2'd2, 2'd0, RING_PLUS},
        '{2'd3, 2'd1, RING_PLUS}, NO_TERM},
      '{'{2'd1, 2'd2, RING_PLUS}, '{2'd3, 2'd2, RING_PLUS}, '{2'd0, 2'd2, RING_MINUS},
        NO_TERM, NO_TERM},
      '{'{2'd1, 2'd0, RING_FLIP}, '{2'd3, 2'd2, RING_MINUS}, '{2'd1, 2'd0, RING_MINUS},
        '{2'd1, 2'd2, RING_MINUS}, '{2'd3, 2'd0, RING_MINUS}},
      '{'{2'd3, 2'd2, RING_MINUS}, '{2'd0, 2'd1, RING_MINUS}, '{2'd0, 2'd2, RING_PLUS},
        '{2'd3, 2'd1, RING_PLUS}, NO_TERM},
      '{'{2'd3, 2'd0, RING_PLUS}, '{2'd3, 2'd2, RING_PLUS}, '{2'd3, 2'd1, RING_MINUS},
        NO_TERM, NO_TERM},
      '{'{2'd0, 2'd3, RING_PLUS}, '{2'd2, 2'd3, RING_PLUS}, '{2'd1, 2'd3, RING_MINUS},
        NO_TERM, NO_TERM},
      '{'{2'd1, 2'd0, RING_MINUS}, '{2'd2, 2'd3, RING_MINUS}, '{2'd1, 2'd3, RING_PLUS},
        '{2'd2, 2'd0, RING_PLUS}, NO_TERM},
      '{'{2'd0, 2'd1, RING_FLIP}, '{2'd0, 2'd1, RING_MINUS}, '{2'd2, 2'd3, RING_MINUS},
        '{2'd0, 2'd3, RING_MINUS}, '{2'd2, 2'd1, RING_MINUS}},
      '{'{2'd2, 2'd1, RING_PLUS}, '{2'd2, 2'd3, RING_PLUS}, '{2'd2, 2'd0, RING_MINUS},
        NO_TERM, NO_TERM},
      '{'{2'd1, 2'd2, RING_MINUS}, '{2'd0, 2'd3, RING_MINUS}, '{2'd1, 2'd3, RING_PLUS},
        '{2'd0, 2'd2, RING_PLUS}, NO_TERM},
      '{'{2'd1, 2'd0, RING_PLUS}, '{2'd1, 2'd2, RING_PLUS}, '{2'd1, 2'd3, RING_MINUS},
        NO_TERM, NO_TERM},
      '{'{2'd0, 2'd1, RING_PLUS}, '{2'd0, 2'd3, RING_PLUS}, '{2'd0, 2'd2, RING_MINUS},
        NO_TERM, NO_TERM},
      '{NO_TERM, NO_TERM, NO_TERM, NO_TERM, NO_TERM}
   };

endpackage

`default_nettype wire

// ----- hw/rtl/srx_if.sv -----
`default_nettype none

// input channel: one basis state with its ring
interface srx_req_if;
   logic                                    valid;
   logic                                    ready;
   logic [srx_pkg::STATE_W-1:0]             basis_state;
   logic [srx_pkg::SITE_W-1:0]              site_first;
   logic [srx_pkg::SITE_W-1:0]              site_second;
   logic [srx_pkg::SITE_W-1:0]              site_third;
   logic [srx_pkg::SITE_W-1:0]              site_fourth;
   logic signed [srx_pkg::STRENGTH_W-1:0]   ring_strength;

   modport source (
      output valid, basis_state, site_first, site_second, site_third, site_fourth,
             ring_strength,
      input  ready
   );
   modport sink (
      input  valid, basis_state, site_first, site_second, site_third, site_fourth,
             ring_strength,
      output ready
   );
endinterface

// result channel: one term
interface srx_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                term_kind;
   logic [srx_pkg::STATE_W-1:0]         target_state;
   logic signed [srx_pkg::COEF_W-1:0]   coefficient;
   logic                                last_term;

   modport source (
      output valid, term_kind, target_state, coefficient, last_term,
      input  ready
   );
   modport sink (
      input  valid, term_kind, target_state, coefficient, last_term,
      output ready
   );
endinterface

`default_nettype wire

// ----- hw/rtl/srx_term_gen.sv -----
`default_nettype none

module srx_term_gen (
   input  srx_pkg::item_type                      item,
   input  logic [srx_pkg::TERM_IDX_W-1:0]         term_idx,
   output srx_pkg::term_type                      term
);
   import srx_pkg::*;

   logic [STATE_W-1:0]       state_masked;
   logic [STATE_W-1:0]       site_mask [RING_W];
   logic [SITE_W-1:0]        sites [RING_W];
   logic [RING_W-1:0]        pattern;
   logic [OFF_IDX_W-1:0]     off_idx;
   ring_term_type            entry;
   logic [1:0]               up_far;
   logic [1:0]               down_far;
   logic [STATE_W-1:0]       next_state;
   logic signed [COEF_W-1:0] j_ext;
   logic signed [COEF_W-1:0] off_coef;

   assign sites[0] = item.site_first;
   assign sites[1] = item.site_second;
   assign sites[2] = item.site_third;
   assign sites[3] = item.site_fourth;

   // spins of the four ring sites
   assign state_masked = item.basis_state & STATE_MASK;
   always_comb begin
      for (int i = 0; i < RING_W; i++) begin
         site_mask[i] = (STATE_W'(1) << sites[i]) & STATE_MASK;
         pattern[i]   = |(state_masked & site_mask[i]);
      end
   end

   // table entry of the current off-diagonal term
   assign off_idx  = (term_idx == '0) ? '0 : OFF_IDX_W'(term_idx - TERM_IDX_W'(1));
   assign entry    = RING_TABLE[pattern][off_idx];
   assign up_far   = entry.up + 2'd2;
   assign down_far = entry.down + 2'd2;

   // raise then lower, and the opposite pair too on a four-site flip
   always_comb begin
      next_state = (state_masked | site_mask[entry.up]) & ~site_mask[entry.down];
      if (entry.kind == RING_FLIP) begin
         next_state = (next_state | site_mask[up_far]) & ~site_mask[down_far];
      end
   end

   // coefficients in 20 fraction bits: J/16 -> J, J/8 -> 2J, J/2 -> 8J
   assign j_ext = COEF_W'(item.ring_strength);
   always_comb begin
      unique case (entry.kind)
         RING_PLUS:  off_coef = j_ext <<< 1;
         RING_MINUS: off_coef = -(j_ext <<< 1);
         RING_FLIP:  off_coef = j_ext <<< 3;
         default:    off_coef = j_ext <<< 1;
      endcase
   end

   // diagonal term first, then the table terms
   always_comb begin
      if (term_idx == '0) begin
         term.term_kind    = TERM_DIAG;
         term.target_state = state_masked;
         term.coefficient  = (^pattern) ? -j_ext : j_ext;
      end else begin
         term.term_kind    = TERM_OFFDIAG;
         term.target_state = next_state & STATE_MASK;
         term.coefficient  = off_coef;
      end
      term.last_term = (term_idx == RING_COUNT[pattern]);
   end

endmodule

`default_nettype wire

// ----- hw/rtl/spin_ring_exchange_terms.sv -----
`default_nettype none

// Four-spin ring exchange term generator. Each accepted item (basis state,
// four ring sites, coupling J) yields its diagonal term first, then the
// off-diagonal terms of its ring spin pattern, one result item per cycle while
// the output side is ready, the final one flagged by last_term. An item
// therefore yields 1, 4, 5 or 6 terms (one plus its off-diagonal count); that
// count, with the single result register feeding the output channel, sets the
// sustained rate. The next item is taken in the cycle that the previous item's
// final term moves into the result register, so items follow each other
// without a gap while the output side keeps ready high. An accepted item is
// held in the item register, and its terms pass through the result register.
module spin_ring_exchange_terms (
   input  logic      clock,
   input  logic      reset,
   srx_req_if.sink   req_ch,
   srx_rsp_if.source rsp_ch
);
   import srx_pkg::*;

   // held item and term counter
   logic                  hold_valid_ff;
   logic                  hold_valid_in;
   item_type              item_ff;
   logic [TERM_IDX_W-1:0] term_idx_ff;
   logic [TERM_IDX_W-1:0] term_idx_in;

   // result register
   logic                  out_valid_ff;
   logic                  out_valid_in;
   term_type              out_ff;

   term_type              gen_term;
   logic                  advance;
   logic                  accept;
   item_type              req_item;

   assign req_item.basis_state   = req_ch.basis_state;
   assign req_item.site_first    = req_ch.site_first;
   assign req_item.site_second   = req_ch.site_second;
   assign req_item.site_third    = req_ch.site_third;
   assign req_item.site_fourth   = req_ch.site_fourth;
   assign req_item.ring_strength = req_ch.ring_strength;

   srx_term_gen u_term_gen (
      .item     (item_ff),
      .term_idx (term_idx_ff),
      .term     (gen_term)
   );

   // a term moves on when the result register is free or being emptied
   assign advance      = hold_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !hold_valid_ff || (advance && gen_term.last_term);
   assign accept       = req_ch.valid && req_ch.ready;

   // next state of the control registers
   always_comb begin
      hold_valid_in = hold_valid_ff;
      term_idx_in   = term_idx_ff;
      if (advance) begin
         if (gen_term.last_term) begin
            hold_valid_in = 1'b0;
            term_idx_in   = '0;
         end else begin
            term_idx_in   = term_idx_ff + TERM_IDX_W'(1);
         end
      end
      if (accept) begin
         hold_valid_in = 1'b1;
         term_idx_in   = '0;
      end
      out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         term_idx_ff   <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         term_idx_ff   <= term_idx_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
      if (advance) begin
         out_ff <= gen_term;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.term_kind    = out_ff.term_kind;
   assign rsp_ch.target_state = out_ff.target_state;
   assign rsp_ch.coefficient  = out_ff.coefficient;
   assign rsp_ch.last_term    = out_ff.last_term;

`ifndef NO_ASSERTIONS
   // counter rests at the diagonal term when no item is held
   a_idle_idx: assert property (@(posedge clock) disable iff (reset)
      !hold_valid_ff |-> term_idx_ff == '0)
      else $error("term counter not cleared while idle");

   // counter never runs past the longest term list
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> term_idx_ff <= TERM_IDX_W'(MAX_TERMS - 1))
      else $error("term counter out of range");

   // every item starts with its diagonal term
   a_diag_first: assert property (@(posedge clock) disable iff (reset)
      advance && term_idx_ff == '0 |-> gen_term.term_kind == TERM_DIAG)
      else $error("first term of an item is not diagonal");

   // an unfinished item keeps its slot and steps to the next term
   a_step: assert property (@(posedge clock) disable iff (reset)
      advance && !gen_term.last_term |=>
         hold_valid_ff && term_idx_ff == TERM_IDX_W'($past(term_idx_ff) + 1))
      else $error("term sequence broken");

   // a new item is only taken once the held one has sent its last term
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      accept && hold_valid_ff |-> advance && gen_term.last_term)
      else $error("item accepted over an unfinished one");
`endif

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
`default_nettype none

module tb_top;
   import srx_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE_WAIT  = 12;

   logic clock = 1'b0;
   logic reset;

   srx_req_if req_bus ();
   srx_rsp_if rsp_bus ();

   spin_ring_exchange_terms DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // run bookkeeping
   term_type   pending_terms [$];
   item_type   seen_item;
   term_type   want_term;
   int         send_idle_pct  = 12;
   int         take_stall_pct = 60;
   int         error_count    = 0;
   int         items_accepted = 0;
   int         terms_checked  = 0;
   int         flips_seen     = 0;
   int         cycle_count    = 0;
   logic [15:0] patterns_seen = '0;

   // clock
   always #2 clock = ~clock;

   // hard stop
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // exchange moves per spin pattern: up site, down site, sign or F for four-site flip
   function automatic string ring_moves(input logic [3:0] pattern);
      case (pattern)
         4'd1:    return "10+ 30+ 20-";
         4'd2:    return "01+ 21+ 31-";
         4'd3:    return "30- 21- 20+ 31+";
         4'd4:    return "12+ 32+ 02-";
         4'd5:    return "10F 32- 10- 12- 30-";
         4'd6:    return "32- 01- 02+ 31+";
         4'd7:    return "30+ 32+ 31-";
         4'd8:    return "03+ 23+ 13-";
         4'd9:    return "10- 23- 13+ 20+";
         4'd10:   return "01F 01- 23- 03- 21-";
         4'd11:   return "21+ 23+ 20-";
         4'd12:   return "12- 03- 13+ 02+";
         4'd13:   return "10+ 12+ 13-";
         4'd14:   return "01+ 03+ 02-";
         default: return "";
      endcase
   endfunction

   // diagonal term then off-diagonal terms for one item
   function automatic void predict_ring_terms(input item_type it);
      logic [STATE_W-1:0]       spins;
      logic [STATE_W-1:0]       next_spins;
      logic [STATE_W-1:0]       site_bit [4];
      logic [SITE_W-1:0]        site [4];
      logic [3:0]               pattern;
      logic signed [COEF_W-1:0] j_wide;
      logic [1:0]               up;
      logic [1:0]               down;
      ring_kind_type            kind;
      term_type                 term;
      string                    moves;
      int                       k;
      spins   = it.basis_state & STATE_MASK;
      site[0] = it.site_first;
      site[1] = it.site_second;
      site[2] = it.site_third;
      site[3] = it.site_fourth;
      j_wide  = COEF_W'(it.ring_strength);
      for (int i = 0; i < 4; i++) begin
         site_bit[i] = (STATE_W'(1) << site[i]) & STATE_MASK;
         pattern[i]  = |(spins & site_bit[i]);
      end
      patterns_seen[pattern] = 1'b1;
      moves = ring_moves(pattern);

      // diagonal: sign follows parity of up spins on the ring
      term.term_kind    = TERM_DIAG;
      term.target_state = spins;
      term.coefficient  = (^pattern) ? -j_wide : j_wide;
      term.last_term    = (moves.len() == 0);
      pending_terms.push_back(term);

      // off-diagonal moves, raise then lower
      for (k = 0; k < moves.len(); k += 4) begin
         up   = 2'(moves[k] - "0");
         down = 2'(moves[k + 1] - "0");
         case (moves[k + 2])
            "F":     kind = RING_FLIP;
            "-":     kind = RING_MINUS;
            default: kind = RING_PLUS;
         endcase
         next_spins = (spins | site_bit[up]) & ~site_bit[down];
         case (kind)
            RING_FLIP: begin
               next_spins = (next_spins | site_bit[2'(up + 2'd2)])
                            & ~site_bit[2'(down + 2'd2)];
               term.coefficient = j_wide * 8;
               flips_seen++;
            end
            RING_MINUS: term.coefficient = -(j_wide * 2);
            default:    term.coefficient = j_wide * 2;
         endcase
         term.term_kind    = TERM_OFFDIAG;
         term.target_state = next_spins & STATE_MASK;
         term.last_term    = (k + 4 >= moves.len());
         pending_terms.push_back(term);
      end
   endfunction

   // capture each accepted item
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         seen_item.basis_state   = req_bus.basis_state;
         seen_item.site_first    = req_bus.site_first;
         seen_item.site_second   = req_bus.site_second;
         seen_item.site_third    = req_bus.site_third;
         seen_item.site_fourth   = req_bus.site_fourth;
         seen_item.ring_strength = req_bus.ring_strength;
         predict_ring_terms(seen_item);
         items_accepted++;
      end
   end

   task automatic check_field(input string name, input logic [COEF_W-1:0] want,
                              input logic [COEF_W-1:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      end
   endtask

   // compare each accepted term with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_terms.size() == 0) begin
            error_count++;
            $display("%0t: unexpected term, expected none actual %h %h %h %h", $time,
                     rsp_bus.term_kind, rsp_bus.target_state, rsp_bus.coefficient,
                     rsp_bus.last_term);
         end else begin
            want_term = pending_terms.pop_front();
            terms_checked++;
            check_field("term_kind", COEF_W'(want_term.term_kind), COEF_W'(rsp_bus.term_kind));
            check_field("target_state", COEF_W'(want_term.target_state),
                        COEF_W'(rsp_bus.target_state));
            check_field("coefficient", want_term.coefficient, rsp_bus.coefficient);
            check_field("last_term", COEF_W'(want_term.last_term), COEF_W'(rsp_bus.last_term));
         end
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= take_stall_pct);
   end

   function automatic item_type make_item(input logic [STATE_W-1:0] basis,
                                          input logic [SITE_W-1:0] s0, s1, s2, s3,
                                          input logic [STRENGTH_W-1:0] strength);
      item_type it;
      it.basis_state   = basis;
      it.site_first    = s0;
      it.site_second   = s1;
      it.site_third    = s2;
      it.site_fourth   = s3;
      it.ring_strength = strength;
      return it;
   endfunction

   // four different ring sites
   function automatic void place_distinct_sites(ref item_type it);
      logic [SITE_W-1:0] s [4];
      logic              clash;
      for (int i = 0; i < 4; i++) begin
         clash = 1'b1;
         while (clash) begin
            s[i]  = SITE_W'($urandom_range(31));
            clash = 1'b0;
            for (int k = 0; k < i; k++)
               if (s[k] == s[i]) clash = 1'b1;
         end
      end
      it.site_first  = s[0];
      it.site_second = s[1];
      it.site_third  = s[2];
      it.site_fourth = s[3];
   endfunction

   // one item, with a random gap in front; valid stays high afterward
   task automatic send_item(input item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.basis_state   <= it.basis_state;
      req_bus.site_first    <= it.site_first;
      req_bus.site_second   <= it.site_second;
      req_bus.site_third    <= it.site_third;
      req_bus.site_fourth   <= it.site_fourth;
      req_bus.ring_strength <= it.ring_strength;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // hold off the sender until every predicted term has come back
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_terms.size() != 0) @(posedge clock);
   endtask

   // every spin pattern on four distinct sites
   task automatic test_spin_patterns();
      item_type   it;
      logic [3:0] pattern;
      for (int p = 0; p < 16; p++) begin
         pattern          = 4'(p);
         it.basis_state   = $urandom;
         it.ring_strength = $urandom;
         place_distinct_sites(it);
         it.basis_state[it.site_first]  = pattern[0];
         it.basis_state[it.site_second] = pattern[1];
         it.basis_state[it.site_third]  = pattern[2];
         it.basis_state[it.site_fourth] = pattern[3];
         send_item(it);
      end
   endtask

   // corner values of state, sites and coupling
   task automatic test_field_extremes();
      send_item(make_item('0, 5'd0, 5'd1, 5'd2, 5'd3, 32'h7FFF_FFFF));
      send_item(make_item('1, 5'd31, 5'd30, 5'd29, 5'd28, 32'h8000_0000));
      send_item(make_item(32'hAAAA_AAAA, 5'd0, 5'd31, 5'd15, 5'd16, 32'hFFFF_FFFF));
      send_item(make_item(32'h5555_5555, 5'd31, 5'd0, 5'd16, 5'd15, 32'h0000_0000));
   endtask

   // coinciding sites: overlapping raise and lower on the same bit
   task automatic test_repeated_sites();
      send_item(make_item(32'h0000_0100, 5'd8, 5'd8, 5'd8, 5'd8, 32'h0001_0000));
      send_item(make_item(32'hFFFF_FEFF, 5'd8, 5'd8, 5'd8, 5'd8, 32'hFFFF_0000));
      send_item(make_item(32'h0000_0008, 5'd3, 5'd3, 5'd7, 5'd7, 32'h0003_8000));
      send_item(make_item(32'h0000_0010, 5'd4, 5'd9, 5'd4, 5'd9, 32'h8000_0001));
   endtask

   // random rings, mostly distinct sites, some with coinciding sites
   task automatic test_random_traffic(input int count);
      item_type it;
      int       shape;
      repeat (count) begin
         shape = $urandom_range(99);
         if (shape < 85) it.basis_state = $urandom;
         else            it.basis_state = $urandom_range(1) ? '1 : '0;
         shape = $urandom_range(99);
         if (shape < 60)      it.ring_strength = $urandom;
         else if (shape < 75) it.ring_strength = 32'($signed($urandom_range(2000)) - 1000);
         else begin
            case ($urandom_range(4))
               0:       it.ring_strength = 32'h7FFF_FFFF;
               1:       it.ring_strength = 32'h8000_0000;
               2:       it.ring_strength = 32'hFFFF_FFFF;
               3:       it.ring_strength = 32'h0000_0001;
               default: it.ring_strength = 32'h0000_0000;
            endcase
         end
         place_distinct_sites(it);
         shape = $urandom_range(99);
         if (shape >= 70 && shape < 85) begin
            case ($urandom_range(2))
               0:       it.site_third = it.site_first;
               1:       it.site_fourth = it.site_second;
               default: begin
                  it.site_second = it.site_first;
                  it.site_fourth = it.site_third;
               end
            endcase
         end else if (shape >= 85) begin
            it.site_first  = SITE_W'($urandom_range(31));
            it.site_second = SITE_W'($urandom_range(31));
            it.site_third  = SITE_W'($urandom_range(31));
            it.site_fourth = SITE_W'($urandom_range(31));
         end
         send_item(it);
      end
   endtask

   initial begin
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.basis_state   = '0;
      req_bus.site_first    = '0;
      req_bus.site_second   = '0;
      req_bus.site_third    = '0;
      req_bus.site_fourth   = '0;
      req_bus.ring_strength = '0;
      rsp_bus.ready         = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // light sender gaps, heavy result stalls
      send_idle_pct  = 12;
      take_stall_pct = 60;
      test_spin_patterns();
      test_field_extremes();
      test_repeated_sites();
      test_random_traffic(80);
      wait_drained();

      // heavy sender gaps, light result stalls
      send_idle_pct  = 60;
      take_stall_pct = 12;
      test_random_traffic(80);
      wait_drained();

      // back to back on both sides
      send_idle_pct  = 0;
      take_stall_pct = 0;
      test_random_traffic(80);
      wait_drained();
      repeat (SETTLE_WAIT) @(posedge clock);

      $display("covered: %0d items, %0d terms, %0d of 16 spin patterns, %0d ring flips",
               items_accepted, terms_checked, $countones(patterns_seen), flips_seen);
      $display("directed corners, coinciding sites and three stall mixes, %0d mismatches",
               error_count);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
hw/rtl/srx_pkg.sv
hw/rtl/srx_if.sv
hw/rtl/srx_term_gen.sv
hw/rtl/spin_ring_exchange_terms.sv
sim/tb_top.sv
